[sv/xxh_pkg.sv]
`default_nettype none

package xxh_pkg;

   // xxHash32 primes
   localparam logic [31:0] PRIME1 = 32'd2654435761;
   localparam logic [31:0] PRIME2 = 32'd2246822519;
   localparam logic [31:0] PRIME3 = 32'd3266489917;
   localparam logic [31:0] PRIME4 = 32'd668265263;
   localparam logic [31:0] PRIME5 = 32'd374761393;

   // sequencer states
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_LOAD   = 9'b000000010,
      ST_MERGE  = 9'b000000100,
      ST_RND_A  = 9'b000001000,
      ST_RND_B  = 9'b000010000,
      ST_RND_C  = 9'b000100000,
      ST_AVAL_A = 9'b001000000,
      ST_AVAL_B = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   // which kind of round the shared multiplier is running
   typedef enum logic [2:0] {
      PH_LANES = 3'b001,
      PH_WORDS = 3'b010,
      PH_BYTES = 3'b100
   } phase_type;

   // rotate left by a fixed amount
   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   // initial lane value derived from the seed
   function automatic logic [31:0] lane_init(input logic [31:0] seed, input logic [1:0] k);
      logic [31:0] v;
      case (k)
         2'd0:    v = seed + PRIME1 + PRIME2;
         2'd1:    v = seed + PRIME2;
         2'd2:    v = seed;
         default: v = seed - PRIME1;
      endcase
      lane_init = v;
   endfunction

endpackage

`default_nettype wire

[sv/xxhash32_stream_hasher_core.sv]
`default_nettype none

// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | req_data_word, req_byte_count, req_last
// rsp     | out       | rsp_valid/rsp_ready  | rsp_hash
// csr     | in        | csr_valid/csr_ready  | csr_seed
//
// One 32x32 multiplier is shared by every round; a round runs ST_RND_A (mul),
// ST_RND_B (add, rotate), ST_RND_C (mul). A word that does not complete a
// stripe is only buffered; a word that completes a stripe runs four lane
// rounds. A last item adds load, merge, a round per buffered word and per tail
// byte, and the avalanche. Reset is synchronous; req_ready is high only while idle.
// The finished hash sits in an output register; a new message can start while
// it waits, and the sequencer holds in its final step until the register frees.

module xxhash32_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_seed
);

   xxh_pkg::state_type state_ff, state_in;
   xxh_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [31:0] word_ff, word_in;
   logic [1:0]  tail_ff, tail_in;
   logic        fin_ff, fin_in;
   logic [31:0] held_ff [3];
   logic [31:0] held_in [3];
   logic [1:0]  hcnt_ff, hcnt_in;
   logic [31:0] len_ff, len_in;
   logic        stripe_ff, stripe_in;
   logic [31:0] lane_ff [4];
   logic [31:0] lane_in [4];
   logic [31:0] seed_ff, seed_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] sum_ff, sum_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] hash_ff, hash_in;

   logic        req_acc;
   logic        csr_acc;
   logic [2:0]  eff_cnt;
   logic [1:0]  ridx;
   logic [2:0]  idx_nxt;
   logic [7:0]  byte_sel;
   logic [31:0] x_sel, k1, k2, acc_sel, rsum, rot_sum, merge_add;
   logic [31:0] mul_a, mul_b, mul_res;
   xxh_pkg::state_type tail_state;

   assign req_ready = (state_ff == xxh_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = hash_ff;

   assign req_acc = req_valid && req_ready;
   assign csr_acc = csr_valid && csr_ready;

   // bytes the item really carries
   assign eff_cnt = (!req_last || (req_byte_count > 3'd4)) ? 3'd4 : req_byte_count;

   assign ridx    = idx_ff[1:0];
   assign idx_nxt = idx_ff + 3'd1;

   // tail byte under the round counter
   always_comb begin
      case (ridx)
         2'd0:    byte_sel = word_ff[7:0];
         2'd1:    byte_sel = word_ff[15:8];
         2'd2:    byte_sel = word_ff[23:16];
         default: byte_sel = word_ff[31:24];
      endcase
   end

   // round operands per phase
   always_comb begin
      unique case (phase_ff)
         xxh_pkg::PH_LANES: begin
            x_sel   = (ridx == 2'd3) ? word_ff : held_ff[ridx];
            k1      = xxh_pkg::PRIME2;
            k2      = xxh_pkg::PRIME1;
            acc_sel = lane_ff[ridx];
         end
         xxh_pkg::PH_WORDS: begin
            x_sel   = held_ff[ridx];
            k1      = xxh_pkg::PRIME3;
            k2      = xxh_pkg::PRIME4;
            acc_sel = h_ff;
         end
         xxh_pkg::PH_BYTES: begin
            x_sel   = {24'd0, byte_sel};
            k1      = xxh_pkg::PRIME5;
            k2      = xxh_pkg::PRIME1;
            acc_sel = h_ff;
         end
         default: begin
            x_sel   = 32'd0;
            k1      = 32'd0;
            k2      = 32'd0;
            acc_sel = 32'd0;
         end
      endcase
   end

   // accumulate and rotate between the two multiplies of a round
   assign rsum = acc_sel + prod_ff;
   always_comb begin
      unique case (phase_ff)
         xxh_pkg::PH_LANES: rot_sum = xxh_pkg::rotl(rsum, 13);
         xxh_pkg::PH_WORDS: rot_sum = xxh_pkg::rotl(rsum, 17);
         xxh_pkg::PH_BYTES: rot_sum = xxh_pkg::rotl(rsum, 11);
         default:           rot_sum = rsum;
      endcase
   end

   // lane merge terms, then the length
   always_comb begin
      case (idx_ff)
         3'd0:    merge_add = xxh_pkg::rotl(lane_ff[0], 1);
         3'd1:    merge_add = xxh_pkg::rotl(lane_ff[1], 7);
         3'd2:    merge_add = xxh_pkg::rotl(lane_ff[2], 12);
         3'd3:    merge_add = xxh_pkg::rotl(lane_ff[3], 18);
         default: merge_add = len_ff;
      endcase
   end

   // shared multiplier, low 32 bits kept
   always_comb begin
      unique case (state_ff)
         xxh_pkg::ST_RND_A: begin
            mul_a = x_sel;
            mul_b = k1;
         end
         xxh_pkg::ST_RND_C: begin
            mul_a = sum_ff;
            mul_b = k2;
         end
         xxh_pkg::ST_AVAL_A: begin
            mul_a = h_ff ^ (h_ff >> 15);
            mul_b = xxh_pkg::PRIME2;
         end
         xxh_pkg::ST_AVAL_B: begin
            mul_a = h_ff ^ (h_ff >> 13);
            mul_b = xxh_pkg::PRIME3;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign mul_res = mul_a * mul_b;

   // after the buffered words: tail bytes or straight to the avalanche
   assign tail_state = (tail_ff != 2'd0) ? xxh_pkg::ST_RND_A : xxh_pkg::ST_AVAL_A;

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      word_in      = word_ff;
      tail_in      = tail_ff;
      fin_in       = fin_ff;
      held_in      = held_ff;
      hcnt_in      = hcnt_ff;
      len_in       = len_ff;
      stripe_in    = stripe_ff;
      lane_in      = lane_ff;
      seed_in      = seed_ff;
      h_in         = h_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      hash_in      = hash_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // seed write reloads the lanes until a stripe went in
      if (csr_acc) begin
         seed_in = csr_seed;
         if (!stripe_ff) begin
            for (int k = 0; k < 4; k++) begin
               lane_in[k] = xxh_pkg::lane_init(csr_seed, 2'(k));
            end
         end
      end

      unique case (state_ff)
         xxh_pkg::ST_IDLE: begin
            if (req_acc) begin
               word_in = req_data_word;
               len_in  = len_ff + {29'd0, eff_cnt};
               fin_in  = req_last;
               tail_in = 2'd0;
               if (eff_cnt == 3'd4) begin
                  if (hcnt_ff == 2'd3) begin
                     hcnt_in   = 2'd0;
                     stripe_in = 1'b1;
                     phase_in  = xxh_pkg::PH_LANES;
                     idx_in    = 3'd0;
                     state_in  = xxh_pkg::ST_RND_A;
                  end else begin
                     held_in[hcnt_ff] = req_data_word;
                     hcnt_in = hcnt_ff + 2'd1;
                     if (req_last) begin
                        state_in = xxh_pkg::ST_LOAD;
                     end
                  end
               end else begin
                  tail_in  = eff_cnt[1:0];
                  state_in = xxh_pkg::ST_LOAD;
               end
            end
         end
         xxh_pkg::ST_LOAD: begin
            h_in     = stripe_ff ? 32'd0 : (seed_ff + xxh_pkg::PRIME5);
            idx_in   = stripe_ff ? 3'd0 : 3'd4;
            state_in = xxh_pkg::ST_MERGE;
         end
         xxh_pkg::ST_MERGE: begin
            h_in   = h_ff + merge_add;
            idx_in = idx_nxt;
            if (idx_ff == 3'd4) begin
               idx_in = 3'd0;
               if (hcnt_ff != 2'd0) begin
                  phase_in = xxh_pkg::PH_WORDS;
                  state_in = xxh_pkg::ST_RND_A;
               end else begin
                  phase_in = xxh_pkg::PH_BYTES;
                  state_in = tail_state;
               end
            end
         end
         xxh_pkg::ST_RND_A: begin
            prod_in  = mul_res;
            state_in = xxh_pkg::ST_RND_B;
         end
         xxh_pkg::ST_RND_B: begin
            sum_in   = rot_sum;
            state_in = xxh_pkg::ST_RND_C;
         end
         xxh_pkg::ST_RND_C: begin
            idx_in   = idx_nxt;
            state_in = xxh_pkg::ST_RND_A;
            unique case (phase_ff)
               xxh_pkg::PH_LANES: begin
                  lane_in[ridx] = mul_res;
                  if (ridx == 2'd3) begin
                     idx_in   = 3'd0;
                     state_in = fin_ff ? xxh_pkg::ST_LOAD : xxh_pkg::ST_IDLE;
                  end
               end
               xxh_pkg::PH_WORDS: begin
                  h_in = mul_res;
                  if (idx_nxt == {1'b0, hcnt_ff}) begin
                     idx_in   = 3'd0;
                     phase_in = xxh_pkg::PH_BYTES;
                     state_in = tail_state;
                  end
               end
               xxh_pkg::PH_BYTES: begin
                  h_in = mul_res;
                  if (idx_nxt == {1'b0, tail_ff}) begin
                     state_in = xxh_pkg::ST_AVAL_A;
                  end
               end
               default: begin
                  state_in = xxh_pkg::ST_IDLE;
               end
            endcase
         end
         xxh_pkg::ST_AVAL_A: begin
            h_in     = mul_res;
            state_in = xxh_pkg::ST_AVAL_B;
         end
         xxh_pkg::ST_AVAL_B: begin
            h_in     = mul_res;
            state_in = xxh_pkg::ST_DONE;
         end
         xxh_pkg::ST_DONE: begin
            // hand off the hash and start a fresh message
            if (!rsp_valid_ff || rsp_ready) begin
               hash_in      = h_ff ^ (h_ff >> 16);
               rsp_valid_in = 1'b1;
               hcnt_in      = 2'd0;
               len_in       = 32'd0;
               stripe_in    = 1'b0;
               for (int k = 0; k < 4; k++) begin
                  lane_in[k] = xxh_pkg::lane_init(seed_ff, 2'(k));
               end
               state_in = xxh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = xxh_pkg::ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xxh_pkg::ST_IDLE;
         phase_ff     <= xxh_pkg::PH_LANES;
         idx_ff       <= 3'd0;
         tail_ff      <= 2'd0;
         fin_ff       <= 1'b0;
         hcnt_ff      <= 2'd0;
         len_ff       <= 32'd0;
         stripe_ff    <= 1'b0;
         seed_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            lane_ff[k] <= xxh_pkg::lane_init(32'd0, 2'(k));
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         tail_ff      <= tail_in;
         fin_ff       <= fin_in;
         hcnt_ff      <= hcnt_in;
         len_ff       <= len_in;
         stripe_ff    <= stripe_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
         lane_ff      <= lane_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      held_ff <= held_in;
      h_ff    <= h_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      hash_ff <= hash_in;
   end

endmodule

`default_nettype wire

[sv/xxh_checker.sv]
`default_nettype none

module xxh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_hash
);

   // no hash pending right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a waiting hash holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hash)))
      else $error("hash dropped or changed while stalled");

   // the last item closes the input until its hash is built
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> !req_ready)
      else $error("input open right after last item");

   // a hash only appears after the sequencer was busy
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("hash without a finished message");

endmodule

bind xxhash32_stream_hasher_core xxh_checker u_xxh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_last  (req_last),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_hash  (rsp_hash)
);

`default_nettype wire
